// ----- src/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and widths for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STAT_W        = 2;
    localparam int DEPTH_DEFAULT = 16;

    // input word: cmd, item_value, zero fill up to whole bytes
    localparam int IN_BITS = CMD_W + DATA_W;
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_VALUE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   load_data;
    } cell_ctl_t;

endpackage

// ----- src/sle_cell.sv -----
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds an entry, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sle_cell
(
    input  logic                      clk,
    input  sle_pkg::cell_ctl_t        ctl,
    input  logic [sle_pkg::DATA_W-1:0] left_data,
    input  logic [sle_pkg::DATA_W-1:0] right_data,
    input  logic [sle_pkg::DATA_W-1:0] match_value,
    output logic [sle_pkg::DATA_W-1:0] data,
    output logic                      match
);
    import sle_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        unique case (ctl.op)
            CELL_LOAD:  data_next = ctl.load_data;
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == match_value);

endmodule

// ----- src/sequential_list_engine.sv -----
// Sequence: the input word is registered, then the cells and count update and the
//   result word is registered; remove-by-value first registers the compare vector.
// Input: a new command is taken only once the last one is reported, set by the
//   load/update/report sequence around the shared row of cells.
// Reset: rst_n clears the entry count, sequencer and output valid; entries
//   themselves are not cleared and are never read above the count.
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells.
// Commands insert at front/back, remove by value, or remove front/back, and
// each command returns one word with status, count, head and tail.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int OUT_W = (((sle_pkg::STAT_W + CNT_W + 2 * sle_pkg::DATA_W) + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input word, low to high: cmd[2:0], item_value[34:3], zero fill
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [sle_pkg::IN_W-1:0] s_tdata,
    // result word, low to high: status, entry_count, head_value, tail_value,
    // zero fill
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata
);
    import sle_pkg::*;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_OFS  = STAT_W;
    localparam int HEAD_OFS = STAT_W + CNT_W;
    localparam int TAIL_OFS = STAT_W + CNT_W + DATA_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [CMD_W-1:0]  cmd_reg,    cmd_next;
    logic [DATA_W-1:0] value_reg,  value_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DEPTH-1:0]  match_reg,  match_next;
    logic [OUT_W-1:0]  out_reg,    out_next;
    logic              out_valid_reg, out_valid_next;

    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic [DATA_W-1:0] left_in    [DEPTH];
    logic [DATA_W-1:0] right_in   [DEPTH];
    cell_ctl_t         cell_ctl   [DEPTH];
    logic [DEPTH-1:0]  cell_match;
    logic [DEPTH-1:0]  live_mask;
    logic [DEPTH-1:0]  shift_from;

    logic              in_fire;
    logic              out_load;
    logic              list_full;
    logic              list_empty;
    logic              found;
    logic [IDX_W-1:0]  tail_idx;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);
    assign found      = |match_reg;
    // every bit at or above the first match: those cells pull from the right
    assign shift_from = match_reg | (~match_reg + DEPTH'(1));
    assign tail_idx   = IDX_W'(count_reg - CNT_W'(1));

    // ------------------------------------------------------------------
    // Row of cells, each wired to its neighbors
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = value_reg;
        end
        else
        begin : g_mid_l
            assign left_in[i] = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in[i] = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in[i] = cell_data[i+1];
        end

        assign live_mask[i] = (CNT_W'(i) < count_reg);

        sle_cell u_cell
        (
            .clk         (clk),
            .ctl         (cell_ctl[i]),
            .left_data   (left_in[i]),
            .right_data  (right_in[i]),
            .match_value (value_reg),
            .data        (cell_data[i]),
            .match       (cell_match[i])
        );
    end

    // ------------------------------------------------------------------
    // Per-cell operation, only in the update cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctl[i].op        = CELL_HOLD;
            cell_ctl[i].load_data = value_reg;
            if (state_reg == ST_EXEC)
            begin
                unique case (cmd_reg)
                    CMD_INS_FRONT:
                    begin
                        if (!list_full)
                            cell_ctl[i].op = (i == 0) ? CELL_LOAD : CELL_LEFT;
                    end
                    CMD_INS_BACK:
                    begin
                        if (!list_full && (count_reg == CNT_W'(i)))
                            cell_ctl[i].op = CELL_LOAD;
                    end
                    CMD_REM_VALUE:
                    begin
                        if (!list_empty && shift_from[i])
                            cell_ctl[i].op = CELL_RIGHT;
                    end
                    CMD_REM_FRONT:
                    begin
                        if (!list_empty)
                            cell_ctl[i].op = CELL_RIGHT;
                    end
                    default:
                    begin
                        cell_ctl[i].op = CELL_HOLD;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, count and status
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        status_next = status_reg;
        match_next  = match_reg;
        out_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = s_tdata[CMD_W-1:0];
                    value_next = s_tdata[CMD_W +: DATA_W];
                    // remove-by-value needs the compare vector first
                    state_next = (s_tdata[CMD_W-1:0] == CMD_REM_VALUE) ? ST_SEARCH
                                                                       : ST_EXEC;
                end
            end
            ST_SEARCH:
            begin
                match_next = cell_match & live_mask;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                status_next = STAT_OK;
                unique case (cmd_reg)
                    CMD_INS_FRONT, CMD_INS_BACK:
                    begin
                        if (list_full)
                            status_next = STAT_FULL;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                    CMD_REM_VALUE:
                    begin
                        if (list_empty)
                            status_next = STAT_EMPTY;
                        else if (!found)
                            status_next = STAT_NOTFOUND;
                        else
                            count_next = count_reg - CNT_W'(1);
                    end
                    CMD_REM_FRONT, CMD_REM_BACK:
                    begin
                        if (list_empty)
                            status_next = STAT_EMPTY;
                        else
                            count_next = count_reg - CNT_W'(1);
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
                state_next = ST_REPORT;
            end
            default:
            begin
                // hold the report until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_next = out_reg;
        if (out_load)
        begin
            out_next = '0;
            out_next[STAT_W-1:0]        = status_reg;
            out_next[CNT_OFS +: CNT_W]  = count_reg;
            if (!list_empty)
            begin
                out_next[HEAD_OFS +: DATA_W] = cell_data[0];
                out_next[TAIL_OFS +: DATA_W] = cell_data[tail_idx];
            end
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        match_reg  <= match_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- src/sle_checker.sv -----
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker #(
    parameter int DEPTH = sle_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int OUT_W = (((sle_pkg::STAT_W + CNT_W + 2 * sle_pkg::DATA_W) + 7) / 8) * 8
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_W-1:0]         m_tdata
);
    import sle_pkg::*;

    localparam int CNT_OFS  = STAT_W;
    localparam int HEAD_OFS = STAT_W + CNT_W;
    localparam int TAIL_OFS = STAT_W + CNT_W + DATA_W;

    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_count;

    assign r_status = m_tdata[STAT_W-1:0];
    assign r_count  = m_tdata[CNT_OFS +: CNT_W];

    // one command in flight: no word taken right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (r_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (r_count == '0)) |->
            ((m_tdata[HEAD_OFS +: DATA_W] == '0) && (m_tdata[TAIL_OFS +: DATA_W] == '0)))
        else $error("empty list reports nonzero head or tail");

    a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((r_status != STAT_FULL || r_count == CNT_W'(DEPTH)) &&
                      (r_status != STAT_EMPTY || r_count == '0)))
        else $error("refusal status does not match count");

endmodule

bind sequential_list_engine sle_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .OUT_W (OUT_W)
) u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
